/* design/mtt_pkg.sv */
`default_nettype none

package mtt_pkg;

    localparam int DEF_TIMER_SLOTS = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int FIRE_W          = $clog2(MAX_RESULTS + 1);
    localparam int TIME_W          = 32;
    localparam int SLOT_FIELD_W    = 4;
    localparam int MODE_W          = 3;
    localparam int IN_DATA_W       = 72;
    localparam int OUT_DATA_W      = 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC = 3'd0,
        MODE_FREE  = 3'd1,
        MODE_START = 3'd2,
        MODE_STOP  = 3'd3,
        MODE_CHPER = 3'd4,
        MODE_TICK  = 3'd5
    } t_mode;

    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_FIRE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALLOC,
        S_OP_CHK,
        S_OP_EXE,
        S_ACK,
        S_TICK_RD,
        S_TICK_CMP,
        S_TICK_RLD,
        S_TICK_PUSH,
        S_TICK_END
    } t_state;

    typedef struct packed {
        logic              reload;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] expiry;
    } t_slot_rec;

endpackage

`default_nettype wire

/* design/mtt_slot_ram.sv */
`default_nettype none

module mtt_slot_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire mtt_pkg::t_slot_rec i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output mtt_pkg::t_slot_rec     o_rdata
);
    import mtt_pkg::*;

    t_slot_rec r_mem [DEPTH];
    t_slot_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* design/mtt_alu.sv */
`default_nettype none

module mtt_alu (
    input  wire logic [mtt_pkg::TIME_W-1:0] i_a,
    input  wire logic [mtt_pkg::TIME_W-1:0] i_b,
    input  wire logic                       i_sub,
    output logic      [mtt_pkg::TIME_W-1:0] o_sum,
    output logic                            o_neg
);
    import mtt_pkg::*;

    logic [TIME_W-1:0] b_op;

    // Subtract as add of the complement plus one
    assign b_op  = i_sub ? ~i_b : i_b;
    assign o_sum = i_a + b_op + TIME_W'(i_sub);
    assign o_neg = o_sum[TIME_W-1];

endmodule

`default_nettype wire

/* design/multi_slot_timer_table.sv */
`default_nettype none

// Timer slot table with one-shot and auto-reload timers.
// Slave channel carries one request: tuser holds the operation (allocate, free,
// start, stop, change period, tick) and tdata the slot, period, reload flag
// and the current millisecond time. Master channel returns results: tuser says
// acknowledge or fire, tdata gives slot and success, tlast marks the final
// result of a request. Ticks with nothing expired, and unknown operations,
// give no result.
// One request is worked on at a time; tready is high only while idle.
// Free and stop are checked and acknowledged; start and change period also
// read and rewrite the slot record first; allocate searches for a free slot
// (the search walks the used marks one per cycle). A tick walks the slots in
// order, passing over unused or stopped slots one per cycle; each used and
// running slot is read from the slot RAM and compared on the shared adder, and
// an expired one is re-armed if it reloads and then pushed; a close step sends
// the last fire. A tick yields at most 16 fire results; stalls hold any push.
// Results leave through a single output register; when the receiver stalls
// the sequencer holds before pushing the next result, so nothing is lost.
// Synchronous reset clears the used and running marks and the output; period,
// expiry and reload live in RAM and are written by allocate before use.
module multi_slot_timer_table #(
    parameter int TIMER_SLOTS = mtt_pkg::DEF_TIMER_SLOTS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // [3:0] slot_index, [35:4] new_period, [36] reload_mode, [68:37] now_time
    input  wire logic [mtt_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // [2:0] mode
    input  wire logic [mtt_pkg::MODE_W-1:0]     i_s_tuser,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // [3:0] result_slot, [4] success
    output logic      [mtt_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic                                o_m_tlast,
    // [0] result_kind
    output logic                                o_m_tuser
);
    import mtt_pkg::*;

    localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_W  = $clog2(TIMER_SLOTS + 1);

    // Sequencer and request registers
    t_state                  r_state, n_state;
    t_mode                   r_mode, n_mode;
    logic [SLOT_FIELD_W-1:0] r_idx, n_idx;
    logic [TIME_W-1:0]       r_period, n_period;
    logic                    r_reload, n_reload;
    logic [TIME_W-1:0]       r_now, n_now;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [FIRE_W-1:0]       r_fires, n_fires;

    // Slot flags held in flops so reset clears them at once
    logic [TIMER_SLOTS-1:0]  r_used, n_used;
    logic [TIMER_SLOTS-1:0]  r_running, n_running;

    // Pending fire result, held until it is known whether it is the last
    logic                    r_pend_valid, n_pend_valid;
    logic [SLOT_FIELD_W-1:0] r_pend_slot, n_pend_slot;
    logic [SLOT_FIELD_W-1:0] r_ack_slot, n_ack_slot;
    logic                    r_ack_ok, n_ack_ok;

    // Output register
    logic                    r_out_valid, n_out_valid;
    logic                    r_out_kind, n_out_kind;
    logic [SLOT_FIELD_W-1:0] r_out_slot, n_out_slot;
    logic                    r_out_ok, n_out_ok;
    logic                    r_out_last, n_out_last;

    // Slot RAM and shared adder
    logic                    ram_we, ram_re;
    logic [SLOT_W-1:0]       ram_waddr, ram_raddr;
    t_slot_rec               ram_wdata, ram_rdata;
    logic [TIME_W-1:0]       alu_b, alu_sum;
    logic                    alu_sub, alu_neg;

    logic                    out_free;
    logic                    s_accept;
    logic [SLOT_W-1:0]       cnt_addr, idx_addr;
    logic                    cnt_end, idx_ok;

    mtt_slot_ram #(
        .DEPTH  (TIMER_SLOTS),
        .ADDR_W (SLOT_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    mtt_alu u_alu (
        .i_a   (r_now),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_sum (alu_sum),
        .o_neg (alu_neg)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign cnt_addr   = r_cnt[SLOT_W-1:0];
    assign idx_addr   = SLOT_W'(r_idx);
    assign cnt_end    = (r_cnt == CNT_W'(TIMER_SLOTS));
    assign idx_ok     = (7'(r_idx) < 7'(TIMER_SLOTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_used       <= '0;
            r_running    <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_cnt        <= '0;
            r_fires      <= '0;
        end else begin
            r_state      <= n_state;
            r_used       <= n_used;
            r_running    <= n_running;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            r_cnt        <= n_cnt;
            r_fires      <= n_fires;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_idx       <= n_idx;
        r_period    <= n_period;
        r_reload    <= n_reload;
        r_now       <= n_now;
        r_pend_slot <= n_pend_slot;
        r_ack_slot  <= n_ack_slot;
        r_ack_ok    <= n_ack_ok;
        r_out_kind  <= n_out_kind;
        r_out_slot  <= n_out_slot;
        r_out_ok    <= n_out_ok;
        r_out_last  <= n_out_last;
    end

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_idx        = r_idx;
        n_period     = r_period;
        n_reload     = r_reload;
        n_now        = r_now;
        n_cnt        = r_cnt;
        n_fires      = r_fires;
        n_used       = r_used;
        n_running    = r_running;
        n_pend_valid = r_pend_valid;
        n_pend_slot  = r_pend_slot;
        n_ack_slot   = r_ack_slot;
        n_ack_ok     = r_ack_ok;
        // Drop the output once taken
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_kind   = r_out_kind;
        n_out_slot   = r_out_slot;
        n_out_ok     = r_out_ok;
        n_out_last   = r_out_last;

        ram_we    = 1'b0;
        ram_waddr = cnt_addr;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = cnt_addr;
        alu_b     = ram_rdata.period;
        alu_sub   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_mode   = t_mode'(i_s_tuser);
                    n_idx    = i_s_tdata[3:0];
                    n_period = i_s_tdata[35:4];
                    n_reload = i_s_tdata[36];
                    n_now    = i_s_tdata[68:37];
                    n_cnt    = '0;
                    n_fires  = '0;
                    unique case (t_mode'(i_s_tuser))
                        MODE_ALLOC: n_state = S_ALLOC;
                        MODE_FREE,
                        MODE_START,
                        MODE_STOP,
                        MODE_CHPER: n_state = S_OP_CHK;
                        MODE_TICK:  n_state = S_TICK_RD;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end

            S_ALLOC: begin
                if (cnt_end) begin
                    n_ack_slot = '0;
                    n_ack_ok   = 1'b0;
                    n_state    = S_ACK;
                end else if (!r_used[cnt_addr]) begin
                    n_used[cnt_addr]    = 1'b1;
                    n_running[cnt_addr] = 1'b0;
                    ram_we           = 1'b1;
                    ram_waddr        = cnt_addr;
                    ram_wdata.reload = r_reload;
                    ram_wdata.period = r_period;
                    ram_wdata.expiry = '0;
                    n_ack_slot       = SLOT_FIELD_W'(r_cnt);
                    n_ack_ok         = 1'b1;
                    n_state          = S_ACK;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            S_OP_CHK: begin
                n_ack_slot = r_idx;
                n_ack_ok   = 1'b0;
                n_state    = S_ACK;
                if (idx_ok && r_used[idx_addr]) begin
                    n_ack_ok = 1'b1;
                    unique case (r_mode)
                        MODE_FREE: begin
                            n_used[idx_addr]    = 1'b0;
                            n_running[idx_addr] = 1'b0;
                        end
                        MODE_STOP: begin
                            n_running[idx_addr] = 1'b0;
                        end
                        default: begin
                            // Start and change period rewrite the slot record
                            ram_re    = 1'b1;
                            ram_raddr = idx_addr;
                            n_state   = S_OP_EXE;
                        end
                    endcase
                end
            end

            S_OP_EXE: begin
                ram_we    = 1'b1;
                ram_waddr = idx_addr;
                if (r_mode == MODE_START) begin
                    alu_b               = ram_rdata.period;
                    ram_wdata.expiry    = alu_sum;
                    n_running[idx_addr] = 1'b1;
                end else begin
                    alu_b            = r_period;
                    ram_wdata.period = r_period;
                    if (r_running[idx_addr]) begin
                        ram_wdata.expiry = alu_sum;
                    end
                end
                n_state = S_ACK;
            end

            S_ACK: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_ACK;
                    n_out_slot  = r_ack_slot;
                    n_out_ok    = r_ack_ok;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            S_TICK_RD: begin
                if (cnt_end || (r_fires == FIRE_W'(MAX_RESULTS))) begin
                    n_state = S_TICK_END;
                end else if (r_used[cnt_addr] && r_running[cnt_addr]) begin
                    ram_re    = 1'b1;
                    ram_raddr = cnt_addr;
                    n_state   = S_TICK_CMP;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            S_TICK_CMP: begin
                // Expired when now minus expiry is not negative
                alu_b   = ram_rdata.expiry;
                alu_sub = 1'b1;
                if (alu_neg) begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_TICK_RD;
                end else if (ram_rdata.reload) begin
                    n_state = S_TICK_RLD;
                end else begin
                    n_running[cnt_addr] = 1'b0;
                    n_state             = S_TICK_PUSH;
                end
            end

            S_TICK_RLD: begin
                // Re-arm at now plus period
                alu_b            = ram_rdata.period;
                ram_we           = 1'b1;
                ram_waddr        = cnt_addr;
                ram_wdata.expiry = alu_sum;
                n_state          = S_TICK_PUSH;
            end

            S_TICK_PUSH: begin
                // Push the earlier fire (not last), then hold this one
                if (!r_pend_valid || out_free) begin
                    if (r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = KIND_FIRE;
                        n_out_slot  = r_pend_slot;
                        n_out_ok    = 1'b1;
                        n_out_last  = 1'b0;
                    end
                    n_pend_valid = 1'b1;
                    n_pend_slot  = SLOT_FIELD_W'(r_cnt);
                    n_fires      = r_fires + 1'b1;
                    n_cnt        = r_cnt + 1'b1;
                    n_state      = S_TICK_RD;
                end
            end

            S_TICK_END: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = KIND_FIRE;
                    n_out_slot   = r_pend_slot;
                    n_out_ok     = 1'b1;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_ok, r_out_slot};
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_kind;

`ifndef ASSERT_OFF
    a_fire_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == KIND_FIRE)) |-> o_m_tdata[4])
        else $error("fire result without success");

    a_run_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_running & ~r_used) == '0))
        else $error("running slot not marked used");

    a_fire_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fires <= FIRE_W'(MAX_RESULTS)))
        else $error("tick fired more results than allowed");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");
`endif

endmodule

`default_nettype wire
